// File: rtl/core/ahqm_pkg.sv
`default_nettype none
package ahqm_pkg;

  // default longest hop in samples
  localparam int unsigned MAX_HOP_DEF = 1024;

  // width of the shared divide, root and log datapaths
  localparam int unsigned UW = 64;

  // configuration register indexes
  localparam logic [1:0] REG_CLIP    = 2'd0;
  localparam logic [1:0] REG_SILENCE = 2'd1;
  localparam logic [1:0] REG_NOISE   = 2'd2;

  localparam logic [14:0] CLIP_RST    = 15'd31000;
  localparam logic [14:0] SILENCE_RST = 15'd100;
  localparam logic [14:0] NOISE_RST   = 15'd75;

  // 10*log10(2) in q16, turns a q16 log2 of a power ratio into db q8.8
  localparam logic signed [18:0] DB_PER_LOG2 = 19'sd197283;

  // log2 of x with 16 fraction bits, truncated; constant arguments only
  function automatic logic [21:0] log2_q16_f(input logic [63:0] x);
    logic [63:0] xs;
    logic [5:0]  p;
    logic [32:0] y;
    logic [65:0] yy;
    logic [15:0] f;
    xs = x;
    p  = 6'd63;
    f  = '0;
    for (int i = 0; i < 63; i++) begin
      if (!xs[63] && p != 6'd0) begin
        xs = xs << 1;
        p  = p - 6'd1;
      end
    end
    y = {1'b0, xs[63:32]};
    for (int i = 0; i < 16; i++) begin
      yy = y * y;
      yy = yy >> 31;
      f  = {f[14:0], 1'b0};
      if (yy[32]) begin
        f[0] = 1'b1;
        y    = yy[33:1];
      end else begin
        y = yy[32:0];
      end
    end
    return {p, f};
  endfunction

  localparam logic [21:0] LOG2_FULL_SCALE = log2_q16_f(64'd32767);

  // sequencer step, tells the datapath what to do this cycle
  typedef enum logic [3:0] {
    OP_IDLE, OP_PRD1, OP_PRD2, OP_PRD3, OP_DIV_DC, OP_DIV_RMS, OP_SQRT_RMS,
    OP_DIV_CR, OP_SQRT_CR, OP_LOG_SQ, OP_LOG_N, OP_LOG_NF, OP_DB1, OP_DB2, OP_OUT
  } op_t;

  typedef struct packed {
    logic acc;
    logic start;
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic hop_end;
    logic div_done;
    logic sqrt_done;
    logic log_done;
  } stat_t;

  // one result, dc_offset in the lowest bits
  typedef struct packed {
    logic               healthy;
    logic [31:0]        hop_number;
    logic [15:0]        silent_hops;
    logic               signal_present;
    logic signed [15:0] level_dbfs;
    logic [14:0]        snr_db;
    logic [13:0]        crest_factor;
    logic               clipping;
    logic [10:0]        clip_count;
    logic [14:0]        peak_level;
    logic [23:0]        rms_level;
    logic signed [23:0] dc_offset;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/audio_hop_quality_meter.sv
`default_nettype none
// channel   dir  tdata (low bit up)                                 tlast
// in_       in   sample[15:0]                                       last
// out_      out  dc_offset, rms_level, peak_level, clip_count,      -
//                clipping, crest_factor, snr_db, level_dbfs,
//                signal_present, silent_hops, hop_number, healthy
// cfg_      in   index 0 clip, 1 silence, 2 noise floor             -
//
// samples that do not close a hop are accepted back to back while idle
// the closing sample starts the hop-end sequence: a 64-step restoring divider
// used three times, a two-bit-a-cycle square root used twice, and a log2 unit
// (shift search plus 16 squarings) used three times
// no sample is taken during that sequence; a pending result holds in its register
// reset is synchronous, clears counters and accumulators, sets config defaults
module audio_hop_quality_meter #(
  parameter int unsigned MAX_HOP = ahqm_pkg::MAX_HOP_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [15:0]  in_tdata,   // sample
  input  wire          in_tlast,   // last
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [175:0] out_tdata,  // dc_offset, rms_level, peak_level, clip_count,
                                   // clipping, crest_factor, snr_db, level_dbfs,
                                   // signal_present, silent_hops, hop_number, healthy
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_addr,
  input  wire  [14:0]  cfg_wdata
);
  import ahqm_pkg::*;

  cmd_t  cmd;
  stat_t st;
  res_t  res;

  ahqm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  ahqm_dp #(.MAX_HOP(MAX_HOP)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sample    ($signed(in_tdata)),
    .last      (in_tlast),
    .cmd       (cmd),
    .st        (st),
    .res       (res)
  );

  assign out_tdata = {6'b0, res};

  // a new result only appears while samples are held off
  a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result loaded while accepting samples");

  // healthy needs signal and no clipping
  a_healthy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.healthy) |-> (res.signal_present && !res.clipping))
    else $error("healthy without signal or with clipping");

  // a hop with signal ends the silent run
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.signal_present) |-> (res.silent_hops == 16'd0))
    else $error("silent run not cleared");

  // no sample accepted while the sequencer is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_IDLE) |-> !in_tready)
    else $error("sample accepted during hop-end sequence");

endmodule
`default_nettype wire

// File: rtl/core/ahqm_ctrl.sv
`default_nettype none
module ahqm_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  input  wire               out_tready,
  input  ahqm_pkg::stat_t   st,
  output logic              in_tready,
  output logic              out_tvalid,
  output ahqm_pkg::cmd_t    cmd
);
  import ahqm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PRD1, S_PRD2, S_PRD3, S_DIV_DC, S_DIV_RMS, S_SQRT_RMS, S_DIV_CR,
    S_SQRT_CR, S_LOG_SQ, S_LOG_N, S_LOG_NF, S_DB1, S_DB2, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   start_r, start_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc, load;
  op_t    op;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;
  assign load       = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // step code for the datapath
  always_comb begin
    unique case (state_r)
      S_IDLE:     op = OP_IDLE;
      S_PRD1:     op = OP_PRD1;
      S_PRD2:     op = OP_PRD2;
      S_PRD3:     op = OP_PRD3;
      S_DIV_DC:   op = OP_DIV_DC;
      S_DIV_RMS:  op = OP_DIV_RMS;
      S_SQRT_RMS: op = OP_SQRT_RMS;
      S_DIV_CR:   op = OP_DIV_CR;
      S_SQRT_CR:  op = OP_SQRT_CR;
      S_LOG_SQ:   op = OP_LOG_SQ;
      S_LOG_N:    op = OP_LOG_N;
      S_LOG_NF:   op = OP_LOG_NF;
      S_DB1:      op = OP_DB1;
      S_DB2:      op = OP_DB2;
      S_OUT:      op = OP_OUT;
      default:    op = OP_IDLE;
    endcase
  end

  assign cmd = '{acc: acc, start: start_r, load: load, op: op};

  // hop end sequence
  always_comb begin
    state_nxt = state_r;
    start_nxt = 1'b0;
    unique case (state_r)
      S_IDLE:     if (acc && st.hop_end) state_nxt = S_PRD1;
      S_PRD1:     state_nxt = S_PRD2;
      S_PRD2:     state_nxt = S_PRD3;
      S_PRD3:     begin state_nxt = S_DIV_DC; start_nxt = 1'b1; end
      S_DIV_DC:   if (st.div_done) begin state_nxt = S_DIV_RMS; start_nxt = 1'b1; end
      S_DIV_RMS:  if (st.div_done) begin state_nxt = S_SQRT_RMS; start_nxt = 1'b1; end
      S_SQRT_RMS: if (st.sqrt_done) begin state_nxt = S_DIV_CR; start_nxt = 1'b1; end
      S_DIV_CR:   if (st.div_done) begin state_nxt = S_SQRT_CR; start_nxt = 1'b1; end
      S_SQRT_CR:  if (st.sqrt_done) begin state_nxt = S_LOG_SQ; start_nxt = 1'b1; end
      S_LOG_SQ:   if (st.log_done) begin state_nxt = S_LOG_N; start_nxt = 1'b1; end
      S_LOG_N:    if (st.log_done) begin state_nxt = S_LOG_NF; start_nxt = 1'b1; end
      S_LOG_NF:   if (st.log_done) state_nxt = S_DB1;
      S_DB1:      state_nxt = S_DB2;
      S_DB2:      state_nxt = S_OUT;
      S_OUT:      if (load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ahqm_dp.sv
`default_nettype none
module ahqm_dp #(
  parameter int unsigned MAX_HOP = ahqm_pkg::MAX_HOP_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_addr,
  input  wire  [14:0]        cfg_wdata,
  input  wire  signed [15:0] sample,
  input  wire                last,
  input  ahqm_pkg::cmd_t     cmd,
  output ahqm_pkg::stat_t    st,
  output ahqm_pkg::res_t     res
);
  import ahqm_pkg::*;

  localparam int unsigned NW = $clog2(MAX_HOP + 1);
  localparam int unsigned SW = NW + 16;
  localparam int unsigned QW = NW + 30;

  // configuration
  logic [14:0] clip_th_r, sil_th_r, noise_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_th_r <= CLIP_RST;
      sil_th_r  <= SILENCE_RST;
      noise_r   <= NOISE_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_CLIP)    clip_th_r <= cfg_wdata;
      if (cfg_addr == REG_SILENCE) sil_th_r  <= cfg_wdata;
      if (cfg_addr == REG_NOISE)   noise_r   <= cfg_wdata;
    end
  end

  // per-sample accumulation
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [QW-1:0]        sq_r, sq_nxt;
  logic [14:0]          peak_r, peak_nxt, mag;
  logic [NW-1:0]        clip_r, clip_nxt, cnt_r, cnt_nxt;
  logic [31:0]          sqs;
  logic signed [SW-1:0] h_sum_r;
  logic [QW-1:0]        h_sq_r;
  logic [14:0]          h_peak_r;
  logic [NW-1:0]        h_clip_r, h_n_r;

  assign mag = (sample == 16'sh8000) ? 15'h7fff
             : (sample[15] ? 15'(-sample) : sample[14:0]);
  assign sqs = 32'(sample * sample);
  assign sum_nxt  = sum_r + SW'(sample);
  assign sq_nxt   = sq_r + QW'(sqs);
  assign peak_nxt = (mag > peak_r) ? mag : peak_r;
  assign clip_nxt = clip_r + ((mag > clip_th_r) ? NW'(1) : NW'(0));
  assign cnt_nxt  = cnt_r + NW'(1);
  assign st.hop_end = last || (cnt_r == NW'(MAX_HOP - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      sq_r   <= '0;
      peak_r <= '0;
      clip_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.acc) begin
      if (st.hop_end) begin
        sum_r  <= '0;
        sq_r   <= '0;
        peak_r <= '0;
        clip_r <= '0;
        cnt_r  <= '0;
      end else begin
        sum_r  <= sum_nxt;
        sq_r   <= sq_nxt;
        peak_r <= peak_nxt;
        clip_r <= clip_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // hop snapshot
  always_ff @(posedge clk) begin
    if (cmd.acc && st.hop_end) begin
      h_sum_r  <= sum_nxt;
      h_sq_r   <= sq_nxt;
      h_peak_r <= peak_nxt;
      h_clip_r <= clip_nxt;
      h_n_r    <= cnt_nxt;
    end
  end

  // exact thresholds, one multiply per register stage
  logic [14:0]       nf;
  logic [29:0]       st2_r, nf2_r, pk2_r;
  logic [NW+11:0]    c3277n_r;
  logic [NW+4:0]     clip20_r;
  logic [SW-1:0]     absum_r;
  logic [QW-1:0]     st2n_r, nf2n_r, pk2n_r;
  logic [36:0]       nf2h_r;
  logic [NW+36:0]    nf2hn_r;
  logic              present_r, below_nf_r, below1_r, clipping_r, dc_ok_r;

  assign nf = (noise_r == 15'd0) ? 15'd1 : noise_r;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PRD1: begin
        st2_r    <= sil_th_r * sil_th_r;
        nf2_r    <= nf * nf;
        pk2_r    <= h_peak_r * h_peak_r;
        c3277n_r <= (NW+12)'(h_n_r * 12'd3277);
        clip20_r <= (NW+5)'(h_clip_r * 5'd20);
        absum_r  <= h_sum_r[SW-1] ? SW'(-h_sum_r) : SW'(h_sum_r);
      end
      OP_PRD2: begin
        st2n_r <= QW'(st2_r * h_n_r);
        nf2n_r <= QW'(nf2_r * h_n_r);
        pk2n_r <= QW'(pk2_r * h_n_r);
        nf2h_r <= 37'(nf2_r * 7'd100);
      end
      OP_PRD3: begin
        nf2hn_r    <= (NW+37)'(nf2h_r * h_n_r);
        present_r  <= h_sq_r > st2n_r;
        below_nf_r <= h_sq_r < nf2n_r;
        below1_r   <= h_sq_r < QW'(h_n_r);
        clipping_r <= clip20_r > (NW+5)'(h_n_r);
        dc_ok_r    <= 64'(absum_r) < 64'(c3277n_r);
      end
      default: ;
    endcase
  end

  // restoring divider, one quotient bit a cycle
  logic [UW:0]   div_rem_r, rem_sh;
  logic [UW-1:0] div_q_r, div_den_r;
  logic [6:0]    div_cnt_r;
  logic          div_done_r, div_start, ge;

  assign div_start = cmd.start &&
    (cmd.op == OP_DIV_DC || cmd.op == OP_DIV_RMS || cmd.op == OP_DIV_CR);
  assign rem_sh = {div_rem_r[UW-1:0], div_q_r[UW-1]};
  assign ge     = rem_sh >= {1'b0, div_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r  <= '0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= (div_cnt_r == 7'd1);
      if (div_start) div_cnt_r <= 7'(UW);
      else if (div_cnt_r != 7'd0) div_cnt_r <= div_cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem_r <= '0;
      unique case (cmd.op)
        OP_DIV_DC: begin
          div_q_r   <= UW'(absum_r) << 8;
          div_den_r <= UW'(h_n_r);
        end
        OP_DIV_RMS: begin
          div_q_r   <= UW'(h_sq_r) << 16;
          div_den_r <= UW'(h_n_r);
        end
        default: begin
          div_q_r   <= UW'(pk2n_r) << 16;
          div_den_r <= UW'(h_sq_r);
        end
      endcase
    end else if (div_cnt_r != 7'd0) begin
      div_rem_r <= ge ? rem_sh - {1'b0, div_den_r} : rem_sh;
      div_q_r   <= {div_q_r[UW-2:0], ge};
    end
  end
  assign st.div_done = div_done_r;

  // square root, two radicand bits a cycle
  logic [UW-1:0] sq_v_r, sq_rt_r, sq_b_r, sq_t;
  logic [5:0]    sq_cnt_r;
  logic          sq_done_r, sq_start;

  assign sq_start = cmd.start && (cmd.op == OP_SQRT_RMS || cmd.op == OP_SQRT_CR);
  assign sq_t     = sq_rt_r + sq_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r  <= '0;
      sq_done_r <= 1'b0;
    end else begin
      sq_done_r <= (sq_cnt_r == 6'd1);
      if (sq_start) sq_cnt_r <= 6'(UW / 2);
      else if (sq_cnt_r != 6'd0) sq_cnt_r <= sq_cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_start) begin
      sq_v_r  <= div_q_r;
      sq_rt_r <= '0;
      sq_b_r  <= UW'(1) << (UW - 2);
    end else if (sq_cnt_r != 6'd0) begin
      if (sq_v_r >= sq_t) begin
        sq_v_r  <= sq_v_r - sq_t;
        sq_rt_r <= (sq_rt_r >> 1) + sq_b_r;
      end else begin
        sq_rt_r <= sq_rt_r >> 1;
      end
      sq_b_r <= sq_b_r >> 2;
    end
  end
  assign st.sqrt_done = sq_done_r;

  // log2 unit: normalizing shift a bit a cycle, then one squaring a cycle
  logic [UW-1:0] lg_x_r;
  logic [5:0]    lg_p_r;
  logic [31:0]   lg_y_r;
  logic [63:0]   lg_yy;
  logic [32:0]   lg_ys;
  logic [15:0]   lg_f_r;
  logic [4:0]    lg_cnt_r;
  logic          lg_norm_r, lg_done_r, lg_start;

  assign lg_start = cmd.start &&
    (cmd.op == OP_LOG_SQ || cmd.op == OP_LOG_N || cmd.op == OP_LOG_NF);
  assign lg_yy = lg_y_r * lg_y_r;
  assign lg_ys = lg_yy[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_norm_r <= 1'b0;
      lg_cnt_r  <= '0;
      lg_done_r <= 1'b0;
    end else begin
      lg_done_r <= (lg_cnt_r == 5'd1);
      if (lg_start) begin
        lg_norm_r <= 1'b1;
      end else if (lg_norm_r && (lg_x_r[UW-1] || lg_p_r == 6'd0)) begin
        lg_norm_r <= 1'b0;
        lg_cnt_r  <= 5'd16;
      end else if (lg_cnt_r != 5'd0) begin
        lg_cnt_r <= lg_cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lg_start) begin
      lg_p_r <= 6'd63;
      lg_f_r <= '0;
      unique case (cmd.op)
        OP_LOG_SQ: lg_x_r <= UW'(h_sq_r);
        OP_LOG_N:  lg_x_r <= UW'(h_n_r);
        default:   lg_x_r <= UW'(nf);
      endcase
    end else if (lg_norm_r) begin
      if (lg_x_r[UW-1] || lg_p_r == 6'd0) begin
        lg_y_r <= lg_x_r[UW-1:UW-32];
      end else begin
        lg_x_r <= lg_x_r << 1;
        lg_p_r <= lg_p_r - 6'd1;
      end
    end else if (lg_cnt_r != 5'd0) begin
      lg_f_r <= {lg_f_r[14:0], lg_ys[32]};
      lg_y_r <= lg_ys[32] ? lg_ys[32:1] : lg_ys[31:0];
    end
  end
  assign st.log_done = lg_done_r;

  // capture unit results
  logic signed [23:0] dc_r;
  logic [23:0]        rms_r;
  logic [13:0]        crest_r;
  logic [21:0]        lsq_r, ln_r, lnf_r;

  always_ff @(posedge clk) begin
    if (div_done_r && cmd.op == OP_DIV_DC)
      dc_r <= h_sum_r[SW-1] ? -$signed(div_q_r[23:0]) : $signed(div_q_r[23:0]);
    if (sq_done_r && cmd.op == OP_SQRT_RMS) rms_r <= sq_rt_r[23:0];
    if (sq_done_r && cmd.op == OP_SQRT_CR)
      crest_r <= (sq_rt_r > UW'(16383)) ? 14'h3fff : sq_rt_r[13:0];
    if (lg_done_r) begin
      unique case (cmd.op)
        OP_LOG_SQ: lsq_r <= {lg_p_r, lg_f_r};
        OP_LOG_N:  ln_r  <= {lg_p_r, lg_f_r};
        default:   lnf_r <= {lg_p_r, lg_f_r};
      endcase
    end
  end

  // db scaling, difference then product
  logic signed [24:0] dsnr_r, dfs_r;
  logic signed [43:0] psnr_r, pfs_r, psnr_a, pfs_a;
  logic signed [19:0] snr_v, fs_v;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DB1) begin
      dsnr_r <= $signed({3'b0, lsq_r}) - $signed({3'b0, ln_r}) - $signed({2'b0, lnf_r, 1'b0});
      dfs_r  <= $signed({3'b0, lsq_r}) - $signed({3'b0, ln_r})
              - $signed({2'b0, LOG2_FULL_SCALE, 1'b0});
    end
    if (cmd.op == OP_DB2) begin
      psnr_r <= 44'(dsnr_r * DB_PER_LOG2);
      pfs_r  <= 44'(dfs_r * DB_PER_LOG2);
    end
  end

  // divide by 2^24 toward zero
  assign psnr_a = psnr_r + (psnr_r[43] ? 44'sd16777215 : 44'sd0);
  assign pfs_a  = pfs_r + (pfs_r[43] ? 44'sd16777215 : 44'sd0);
  assign snr_v  = 20'(psnr_a >>> 24);
  assign fs_v   = 20'(pfs_a >>> 24);

  // result register and hop counters
  logic [15:0] silent_r;
  logic [31:0] hop_r;
  logic [15:0] silent_nxt;
  logic        good_snr;
  res_t        res_r;

  assign silent_nxt = present_r ? 16'd0
                    : ((silent_r == 16'hffff) ? silent_r : silent_r + 16'd1);
  assign good_snr   = 64'(h_sq_r) > 64'(nf2hn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silent_r <= '0;
      hop_r    <= '0;
    end else if (cmd.load) begin
      silent_r <= silent_nxt;
      hop_r    <= hop_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r.dc_offset      <= dc_r;
      res_r.rms_level      <= rms_r;
      res_r.peak_level     <= h_peak_r;
      res_r.clip_count     <= (32'(h_clip_r) > 32'd2047) ? 11'h7ff : 11'(h_clip_r);
      res_r.clipping       <= clipping_r;
      res_r.crest_factor   <= (h_sq_r == '0) ? 14'd0 : crest_r;
      if (below_nf_r || snr_v < 20'sd0) res_r.snr_db <= 15'd0;
      else if (snr_v > 20'sd32767)      res_r.snr_db <= 15'h7fff;
      else                              res_r.snr_db <= snr_v[14:0];
      if (below1_r || fs_v < -20'sd25600) res_r.level_dbfs <= -16'sd25600;
      else if (fs_v > 20'sd1)             res_r.level_dbfs <= 16'sd1;
      else                                res_r.level_dbfs <= fs_v[15:0];
      res_r.signal_present <= present_r;
      res_r.silent_hops    <= silent_nxt;
      res_r.hop_number     <= hop_r + 32'd1;
      res_r.healthy        <= !clipping_r && present_r && good_snr && dc_ok_r;
    end
  end
  assign res = res_r;

endmodule
`default_nettype wire

// File: verif/hop_meter_checker.sv
`timescale 1ns / 100ps
module hop_meter_checker (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [15:0]  in_tdata,   // sample
  input  wire          in_tlast,   // last
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire  [175:0] out_tdata,  // dc_offset, rms_level, peak_level, clip_count,
                                   // clipping, crest_factor, snr_db, level_dbfs,
                                   // signal_present, silent_hops, hop_number, healthy
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_addr,
  input  wire  [14:0]  cfg_wdata,
  output int           errors,
  output int           pending
);
  import ahqm_pkg::*;

  localparam int unsigned HOP_LIMIT = MAX_HOP_DEF;

  // shadow registers
  bit [63:0] clip_thr, silence_thr, floor_rms;

  // hop accumulators and counters
  longint    hop_sum;
  bit [63:0] hop_sumsq;
  bit [63:0] hop_peak;
  bit [63:0] hop_clips;
  bit [63:0] hop_len;
  bit [31:0] hops_done;
  bit [63:0] silent_run;

  res_t hop_reports[$];

  function automatic bit [63:0] int_sqrt(input bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 with 16 fraction bits by repeated squaring
  function automatic longint log2_fix(input bit [63:0] x);
    int        p;
    bit [63:0] y;
    longint    f;
    f = 0;
    if (x == 0) return 0;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    y = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 31;
      f = f << 1;
      if (y >= 64'h1_0000_0000) begin
        f = f | 1;
        y = y >> 1;
      end
    end
    return longint'(p) * 65536 + f;
  endfunction

  function automatic longint to_db(input longint d);
    return (d * 64'sd197283) / 64'sd16777216;
  endfunction

  // closes the current hop and works out its report
  function automatic res_t close_hop();
    res_t      r;
    bit [63:0] n, sq, nf, q, crest, rms;
    longint    dc, snr, dbfs, absum;
    bit        clip_flag, present, good_snr, dc_ok;
    n  = hop_len;
    sq = hop_sumsq;
    nf = (floor_rms != 0) ? floor_rms : 64'd1;
    hops_done = hops_done + 1;
    dc = (hop_sum * 256) / longint'(n);
    clip_flag = hop_clips * 20 > n;
    present = sq > silence_thr * silence_thr * n;
    if (present) silent_run = 0;
    else if (silent_run < 65535) silent_run = silent_run + 1;
    if (sq == 0) begin
      crest = 0;
    end else begin
      q = (hop_peak * hop_peak * 65536 * n) / sq;
      crest = int_sqrt(q);
      if (crest > 16383) crest = 16383;
    end
    if (sq < nf * nf * n) begin
      snr = 0;
    end else begin
      snr = to_db(log2_fix(sq) - log2_fix(n) - 2 * log2_fix(nf));
      if (snr < 0) snr = 0;
      if (snr > 32767) snr = 32767;
    end
    if (sq < n) begin
      dbfs = -25600;
    end else begin
      dbfs = to_db(log2_fix(sq) - log2_fix(n) - 2 * log2_fix(64'd32767));
      if (dbfs < -25600) dbfs = -25600;
      if (dbfs > 1) dbfs = 1;
    end
    good_snr = sq > 100 * nf * nf * n;
    absum = (hop_sum < 0) ? -hop_sum : hop_sum;
    dc_ok = absum < longint'(3277 * n);
    rms = int_sqrt((sq * 65536) / n);
    r.dc_offset      = dc[23:0];
    r.rms_level      = rms[23:0];
    r.peak_level     = hop_peak[14:0];
    r.clip_count     = (hop_clips > 2047) ? 11'd2047 : hop_clips[10:0];
    r.clipping       = clip_flag;
    r.crest_factor   = crest[13:0];
    r.snr_db         = snr[14:0];
    r.level_dbfs     = dbfs[15:0];
    r.signal_present = present;
    r.silent_hops    = silent_run[15:0];
    r.hop_number     = hops_done;
    r.healthy        = !clip_flag && present && good_snr && dc_ok;
    hop_sum = 0;
    hop_sumsq = 0;
    hop_peak = 0;
    hop_clips = 0;
    hop_len = 0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch hop %0d %s: got %0d want %0d", hops_done - pending, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  // watch the three ports
  always @(posedge clk) begin
    res_t      got, want;
    longint    s;
    bit [63:0] mag;
    if (!rst_n) begin
      clip_thr = CLIP_RST;
      silence_thr = SILENCE_RST;
      floor_rms = NOISE_RST;
      hop_sum = 0;
      hop_sumsq = 0;
      hop_peak = 0;
      hop_clips = 0;
      hop_len = 0;
      hops_done = 0;
      silent_run = 0;
      hop_reports.delete();
    end else begin
      // results first, they can only match earlier requests
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(res_t)-1:0];
        if (hop_reports.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = hop_reports.pop_front();
          check_field("dc_offset", got.dc_offset, want.dc_offset);
          check_field("rms_level", got.rms_level, want.rms_level);
          check_field("peak_level", got.peak_level, want.peak_level);
          check_field("clip_count", got.clip_count, want.clip_count);
          check_field("clipping", got.clipping, want.clipping);
          check_field("crest_factor", got.crest_factor, want.crest_factor);
          check_field("snr_db", got.snr_db, want.snr_db);
          check_field("level_dbfs", got.level_dbfs, want.level_dbfs);
          check_field("signal_present", got.signal_present, want.signal_present);
          check_field("silent_hops", got.silent_hops, want.silent_hops);
          check_field("hop_number", got.hop_number, want.hop_number);
          check_field("healthy", got.healthy, want.healthy);
        end
      end
      // sample request
      if (in_tvalid && in_tready) begin
        s = longint'($signed(in_tdata));
        mag = (s < 0) ? -s : s;
        if (mag > 32767) mag = 32767;
        hop_sum = hop_sum + s;
        hop_sumsq = hop_sumsq + 64'(s * s);
        if (mag > hop_peak) hop_peak = mag;
        if (mag > clip_thr) hop_clips = hop_clips + 1;
        hop_len = hop_len + 1;
        if (in_tlast || hop_len >= HOP_LIMIT) hop_reports.push_back(close_hop());
      end
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_CLIP:    clip_thr = cfg_wdata;
          REG_SILENCE: silence_thr = cfg_wdata;
          REG_NOISE:   floor_rms = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = hop_reports.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import ahqm_pkg::*;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [15:0]   in_tdata;   // sample
  logic          in_tlast;   // last
  logic          out_tvalid;
  logic          out_tready;
  logic [175:0]  out_tdata;  // dc_offset, rms_level, peak_level, clip_count,
                             // clipping, crest_factor, snr_db, level_dbfs,
                             // signal_present, silent_hops, hop_number, healthy
  logic          cfg_we;
  logic [1:0]    cfg_addr;
  logic [14:0]   cfg_wdata;
  int            errors;
  int            pending;

  int send_idle_pct;
  int recv_stall_pct;
  int recv_hold;
  int samples_sent;

  audio_hop_quality_meter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  hop_meter_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // result side stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      out_tready <= 1'b0;
      recv_hold = recv_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [15:0] s, input bit last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  // all three registers, only once the block has gone quiet
  task automatic write_regs(input logic [14:0] clip, input logic [14:0] sil,
                            input logic [14:0] nf);
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_CLIP;
    cfg_wdata <= clip;
    @(posedge clk);
    cfg_addr <= REG_SILENCE;
    cfg_wdata <= sil;
    @(posedge clk);
    cfg_addr <= REG_NOISE;
    cfg_wdata <= nf;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample(input int kind, input int center);
    int v;
    case (kind)
      0: v = $urandom_range(65535) - 32768;
      1: v = int'($urandom_range(40)) - 20;
      2: begin
        case ($urandom_range(3))
          0: v = 32767;
          1: v = -32768;
          default: v = $urandom_range(65535) - 32768;
        endcase
      end
      default: begin
        v = center + int'($urandom_range(2000)) - 1000;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
    endcase
    return v[15:0];
  endfunction

  // one hop of random content; ends by length, broken ones end on a random flag
  task automatic send_hop(input int len, input bit broken);
    int kind, center;
    kind = $urandom_range(3);
    center = $urandom_range(65535) - 32768;
    for (int i = 0; i < len; i++) begin
      if (broken) send_sample(pick_sample(kind, center), $urandom_range(7) == 0);
      else send_sample(pick_sample(kind, center), i == len - 1);
    end
  endtask

  task automatic random_config();
    case ($urandom_range(3))
      0: write_regs(15'd0, 15'd0, 15'd0);
      1: write_regs(15'h7fff, 15'h7fff, 15'h7fff);
      default: write_regs(15'($urandom_range(32767)), 15'($urandom_range(3000)),
                          15'($urandom_range(3000)));
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_CLIP;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 0;
    samples_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, single-sample hops, silence, threshold edges
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'd100, 1'b0);
    send_sample(16'd100, 1'b1);
    send_sample(16'd101, 1'b1);
    send_sample(16'hfc00, 1'b1);
    // zero thresholds, noise floor of zero taken as one
    write_regs(15'd0, 15'd0, 15'd0);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h000a, 1'b1);
    // top thresholds
    write_regs(15'h7fff, 15'h7fff, 15'h7fff);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'haaaa, 1'b1);
    write_regs(CLIP_RST, SILENCE_RST, NOISE_RST);

    // random phases, one per idling mode
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 62 : 28) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 62 : 28) : 0;
      if (ph > 0) random_config();
      if (ph == 0) recv_hold = 3000;
      if (ph == 1) begin
        // one hop running past the longest length, closed there by length
        for (int i = 0; i < MAX_HOP_DEF + 6; i++) send_sample(pick_sample(0, 0), 1'b0);
        send_sample(16'h0123, 1'b1);
      end
      while (samples_sent < 20 + 200 * (ph + 1) + ((ph >= 1) ? MAX_HOP_DEF + 7 : 0)) begin
        if ($urandom_range(9) == 0) send_hop($urandom_range(1, 20), 1'b1);
        else send_hop(($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24),
                      1'b0);
        if ($urandom_range(29) == 0) begin
          // let everything drain before going on
          in_tvalid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
        end
      end
    end
    send_sample(16'h0000, 1'b1);
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (600) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ahqm_pkg.sv
rtl/core/ahqm_ctrl.sv
rtl/core/ahqm_dp.sv
rtl/core/audio_hop_quality_meter.sv
verif/hop_meter_checker.sv
verif/testbench.sv
